FILE: hw/rtl/lcw_pkg.sv
package lcw_pkg;

    typedef logic [7:0] t_byte;

    typedef struct packed {
        logic [3:0] text_line;
        logic [7:0] cell_index;
        logic [7:0] char_code;
    } t_in_word;

    typedef struct packed {
        logic       is_data;
        logic [7:0] lcd_byte;
        logic       last;
    } t_out_word;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CALC,
        ST_EMIT
    } t_state;

    localparam t_byte      MAX_CELL       = 8'd21;
    localparam t_byte      PAGE_BASE      = 8'hAF;
    localparam t_byte      COL_HI_CMD     = 8'h10;
    localparam t_byte      FONT_FIRST     = 8'h20;
    localparam t_byte      FONT_LAST      = 8'h7E;
    localparam t_byte      CODE_BLANK     = 8'h00;
    localparam logic [3:0] IDX_PAGE       = 4'd0;
    localparam logic [3:0] IDX_COL_HI     = 4'd1;
    localparam logic [3:0] IDX_COL_LO     = 4'd2;
    localparam logic [3:0] IDX_FIRST_DATA = 4'd3;
    localparam logic [3:0] IDX_LAST_BLANK = 4'd7;
    localparam logic [3:0] IDX_LAST_GLYPH = 4'd8;

    // five columns, first column in the top byte
    function automatic logic [39:0] font_row(input logic [6:0] idx);
        logic [39:0] row;
        unique case (idx)
            7'd0:  row = 40'h0000000000;
            7'd1:  row = 40'h00004f0000;
            7'd2:  row = 40'h0007000700;
            7'd3:  row = 40'h147f147f14;
            7'd4:  row = 40'h242a7f2a12;
            7'd5:  row = 40'h2313086462;
            7'd6:  row = 40'h3649552250;
            7'd7:  row = 40'h0005070000;
            7'd8:  row = 40'h001c224100;
            7'd9:  row = 40'h0041221c00;
            7'd10: row = 40'h14083e0814;
            7'd11: row = 40'h08083e0808;
            7'd12: row = 40'h0050300000;
            7'd13: row = 40'h0808080808;
            7'd14: row = 40'h0060600000;
            7'd15: row = 40'h2010080402;
            7'd16: row = 40'h3e5149453e;
            7'd17: row = 40'h00427f4000;
            7'd18: row = 40'h4261514946;
            7'd19: row = 40'h2141454b31;
            7'd20: row = 40'h1814127f10;
            7'd21: row = 40'h2745454539;
            7'd22: row = 40'h3c4a494930;
            7'd23: row = 40'h0171090503;
            7'd24: row = 40'h3649494936;
            7'd25: row = 40'h064949291e;
            7'd26: row = 40'h0036360000;
            7'd27: row = 40'h0056360000;
            7'd28: row = 40'h0814224100;
            7'd29: row = 40'h1414141414;
            7'd30: row = 40'h0041221408;
            7'd31: row = 40'h0201510906;
            7'd32: row = 40'h324979413e;
            7'd33: row = 40'h7e1111117e;
            7'd34: row = 40'h7f49494936;
            7'd35: row = 40'h3e41414122;
            7'd36: row = 40'h7f4141221c;
            7'd37: row = 40'h7f49494941;
            7'd38: row = 40'h7f09090901;
            7'd39: row = 40'h3e4149497a;
            7'd40: row = 40'h7f0808087f;
            7'd41: row = 40'h00417f4100;
            7'd42: row = 40'h2040413f01;
            7'd43: row = 40'h7f08142241;
            7'd44: row = 40'h7f40404040;
            7'd45: row = 40'h7f020c027f;
            7'd46: row = 40'h7f0408107f;
            7'd47: row = 40'h3e4141413e;
            7'd48: row = 40'h7f09090906;
            7'd49: row = 40'h3e4151215e;
            7'd50: row = 40'h7f09192946;
            7'd51: row = 40'h4649494931;
            7'd52: row = 40'h01017f0101;
            7'd53: row = 40'h3f4040403f;
            7'd54: row = 40'h1f2040201f;
            7'd55: row = 40'h3f4038403f;
            7'd56: row = 40'h6314081463;
            7'd57: row = 40'h0708700807;
            7'd58: row = 40'h6151494543;
            7'd59: row = 40'h007f414100;
            7'd60: row = 40'h0204081020;
            7'd61: row = 40'h0041417f00;
            7'd62: row = 40'h0402010204;
            7'd63: row = 40'h4040404040;
            7'd64: row = 40'h0102040000;
            7'd65: row = 40'h2054545478;
            7'd66: row = 40'h7f48484830;
            7'd67: row = 40'h3844444444;
            7'd68: row = 40'h304848487f;
            7'd69: row = 40'h3854545458;
            7'd70: row = 40'h00087e0902;
            7'd71: row = 40'h485454543c;
            7'd72: row = 40'h7f08080870;
            7'd73: row = 40'h00007a0000;
            7'd74: row = 40'h2040403d00;
            7'd75: row = 40'h7f20284400;
            7'd76: row = 40'h00417f4000;
            7'd77: row = 40'h7c0438047c;
            7'd78: row = 40'h7c08040478;
            7'd79: row = 40'h3844444438;
            7'd80: row = 40'h7c14141408;
            7'd81: row = 40'h081414147c;
            7'd82: row = 40'h7c08040408;
            7'd83: row = 40'h4854545424;
            7'd84: row = 40'h04043f4424;
            7'd85: row = 40'h3c4040403c;
            7'd86: row = 40'h1c2040201c;
            7'd87: row = 40'h3c4030403c;
            7'd88: row = 40'h4428102844;
            7'd89: row = 40'h0448300804;
            7'd90: row = 40'h4464544c44;
            7'd91: row = 40'h0836414100;
            7'd92: row = 40'h0000770000;
            7'd93: row = 40'h0041413608;
            7'd94: row = 40'h0402020201;
            default: row = 40'h0000000000;
        endcase
        return row;
    endfunction

endpackage

FILE: hw/rtl/lcw_adder.sv
module lcw_adder
    import lcw_pkg::*;
(
    input  t_byte i_a,
    input  t_byte i_b,
    input  logic  i_cin,
    output t_byte o_sum
);

    logic [8:0] sum_full;

    assign sum_full = {1'b0, i_a} + {1'b0, i_b} + {8'd0, i_cin};
    assign o_sum    = sum_full[7:0];

endmodule

FILE: hw/rtl/lcd_char_cell_writer.sv
// Character cell writer for a page-addressed graphic LCD. Each accepted word (text line,
// cell, ASCII code) becomes three command bytes (page, column high nibble, column low
// nibble) followed by five font columns and a blank spacer for codes 0x20..0x7E, or five
// zero bytes for code 0x00; cells above 21 and all other codes are taken and dropped.
// A drawn word is taken while the sequencer is idle, set up in ST_CALC and then emitted at
// one byte per cycle when the sink never stalls; a dropped word is taken without leaving
// idle. A single 8-bit adder, shared under the sequencer, forms the pixel column, the page
// byte and the column high command byte; the column low byte is the column's low nibble.
// Input is taken only while the sequencer is idle; the last byte may still wait in the
// output register while the next word is accepted.
module lcd_char_cell_writer
    import lcw_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_word  i_in_word,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_word o_out_word
);

    t_state      r_state, n_state;
    logic [3:0]  r_line;
    t_byte       r_cell;
    t_byte       r_code;
    t_byte       r_col;
    logic [39:0] r_glyph;
    logic [3:0]  r_idx;
    logic [3:0]  r_last_idx;
    logic        r_out_valid;
    t_out_word   r_out_word;

    logic        in_acc;
    logic        keep;
    logic        slot_free;
    logic        emit;
    t_byte       alu_a, alu_b, alu_sum;
    logic        alu_cin;
    t_out_word   n_out_word;
    logic [6:0]  font_idx;

    lcw_adder u_adder (
        .i_a   (alu_a),
        .i_b   (alu_b),
        .i_cin (alu_cin),
        .o_sum (alu_sum)
    );

    assign o_in_ready  = (r_state == ST_IDLE);
    assign in_acc      = i_in_valid && o_in_ready;
    assign keep        = (i_in_word.cell_index <= MAX_CELL) &&
                         ((i_in_word.char_code == CODE_BLANK) ||
                          ((i_in_word.char_code >= FONT_FIRST) &&
                           (i_in_word.char_code <= FONT_LAST)));
    assign slot_free   = !r_out_valid || i_out_ready;
    assign emit        = (r_state == ST_EMIT) && slot_free;
    assign font_idx    = r_code[6:0] - FONT_FIRST[6:0];
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc && keep) begin
                    n_state = ST_CALC;
                end
            end
            ST_CALC: begin
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (slot_free && (r_idx == r_last_idx)) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // shared adder: column = cell*6 + 1, page = 0xAF + line, column high command
    always_comb begin
        alu_a   = '0;
        alu_b   = '0;
        alu_cin = 1'b0;
        unique case (r_state)
            ST_CALC: begin
                alu_a   = {r_cell[5:0], 2'b00};
                alu_b   = {r_cell[6:0], 1'b0};
                alu_cin = 1'b1;
            end
            ST_EMIT: begin
                if (r_idx == IDX_PAGE) begin
                    alu_a = PAGE_BASE;
                    alu_b = {4'd0, r_line};
                end else begin
                    alu_a = COL_HI_CMD;
                    alu_b = {4'd0, r_col[7:4]};
                end
            end
            default: begin
                alu_a = '0;
            end
        endcase
    end

    always_comb begin
        n_out_word.is_data = (r_idx >= IDX_FIRST_DATA);
        n_out_word.last    = (r_idx == r_last_idx);
        case (r_idx)
            IDX_PAGE, IDX_COL_HI: n_out_word.lcd_byte = alu_sum;
            IDX_COL_LO:           n_out_word.lcd_byte = {4'd0, r_col[3:0]};
            default:              n_out_word.lcd_byte = r_glyph[39:32];
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_line <= i_in_word.text_line;
            r_cell <= i_in_word.cell_index;
            r_code <= i_in_word.char_code;
        end
        if (r_state == ST_CALC) begin
            r_col <= alu_sum;
            r_idx <= IDX_PAGE;
            if (r_code == CODE_BLANK) begin
                r_glyph    <= '0;
                r_last_idx <= IDX_LAST_BLANK;
            end else begin
                r_glyph    <= font_row(font_idx);
                r_last_idx <= IDX_LAST_GLYPH;
            end
        end
        if (emit) begin
            r_out_word <= n_out_word;
            r_idx      <= r_idx + 4'd1;
            if (r_idx >= IDX_FIRST_DATA) begin
                r_glyph <= {r_glyph[31:0], 8'd0};
            end
        end
    end

    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT) |-> (r_idx <= r_last_idx))
        else $error("byte index ran past the end of the run");

    a_calc_to_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CALC) |=> (r_state == ST_EMIT))
        else $error("setup cycle not followed by byte output");

    a_last_is_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_word.last) |-> r_out_word.is_data)
        else $error("run ended on a command byte");

    a_drop_stays_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && !keep) |=> (r_state == ST_IDLE))
        else $error("dropped word started a run");

endmodule
